FILE: hw/rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// Midtones transfer stretch package
// Shared widths, pipeline depths, register indexes, control types and the
// lane class code used by the lanes, the divider and the top level.
// ----------------------------------------------------------------------------
package mts_pkg;

   // Samples and thresholds use only their low SAMPLE_BITS bits.
   localparam int SAMPLE_BITS = 16;
   localparam int IN_W        = 16;
   localparam int OUT_W       = 8;
   localparam int THR_W       = 32;
   localparam int MID_W       = 17;
   localparam int PROD_W      = 33;
   localparam int NUM_W       = 41;
   localparam int DEN_W       = 33;

   localparam logic [MID_W-1:0] MID_ONE = 17'h10000;
   localparam logic [OUT_W-1:0] OUT_MAX = 8'd255;

   // Pipeline layout: classify, multiply, combine, then one quotient bit per
   // divider stage, then the merge register in the top level.
   localparam int FRONT_STG = 3;
   localparam int DIV_STG   = OUT_W;
   localparam int LANE_STG  = FRONT_STG + DIV_STG;
   localparam int NSTG      = LANE_STG + 1;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_RED_THR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GREEN_THR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLUE_THR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RED_MID   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GREEN_MID = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BLUE_MID  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MODE      = 3'd6;

   localparam logic [THR_W-1:0] THR_RESET = 32'hFFFF_0000;
   localparam logic [MID_W-1:0] MID_RESET = 17'd32768;

   // How a lane's result is formed once the quotient is known.
   typedef enum logic [1:0] {
      CLS_MID,
      CLS_LOW,
      CLS_HIGH,
      CLS_ZERO
   } mts_class_type;

   // Stage load enables from the pipeline control to the lanes.
   typedef struct packed {
      logic [NSTG-1:0] en;
   } mts_ctrl_type;

   function automatic logic [OUT_W-1:0] resolve(input mts_class_type cls,
                                                input logic [OUT_W-1:0] quo);
      logic [OUT_W-1:0] res;
      begin
         case (cls)
            CLS_MID:  res = quo;
            CLS_HIGH: res = OUT_MAX;
            CLS_LOW:  res = '0;
            CLS_ZERO: res = '0;
            default:  res = '0;
         endcase
         return res;
      end
   endfunction

endpackage

FILE: hw/rtl/mts_div.sv
// ----------------------------------------------------------------------------
// Midtones transfer stretch quotient pipeline
// Restoring division, one quotient bit per stage, most significant bit first.
// ----------------------------------------------------------------------------
module mts_div (
   input  logic                                  clock,
   input  mts_pkg::mts_ctrl_type                 ctrl,
   input  logic [mts_pkg::NUM_W-1:0]             num,
   input  logic [mts_pkg::DEN_W-1:0]             den,
   input  mts_pkg::mts_class_type                cls,
   output logic [mts_pkg::OUT_W-1:0]             quo,
   output mts_pkg::mts_class_type                cls_out
);

   logic [mts_pkg::NUM_W-1:0] rem_ff [mts_pkg::DIV_STG];
   logic [mts_pkg::DEN_W-1:0] den_ff [mts_pkg::DIV_STG];
   logic [mts_pkg::OUT_W-1:0] quo_ff [mts_pkg::DIV_STG];
   mts_pkg::mts_class_type    cls_ff [mts_pkg::DIV_STG];

   for (genvar i = 0; i < mts_pkg::DIV_STG; i++) begin : g_stage
      logic [mts_pkg::NUM_W-1:0] rem_prev, trial, rem_in;
      logic [mts_pkg::DEN_W-1:0] den_prev;
      logic [mts_pkg::OUT_W-1:0] quo_prev, quo_in;
      mts_pkg::mts_class_type    cls_prev;

      if (i == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
         assign cls_prev = cls;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign quo_prev = quo_ff[i-1];
         assign cls_prev = cls_ff[i-1];
      end

      // The divisor shifted to the weight of this stage's quotient bit.
      assign trial = mts_pkg::NUM_W'(den_prev) << (mts_pkg::DIV_STG - 1 - i);

      always_comb begin
         rem_in = rem_prev;
         quo_in = quo_prev;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            quo_in[mts_pkg::DIV_STG - 1 - i] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (ctrl.en[mts_pkg::FRONT_STG + i]) begin
            rem_ff[i] <= rem_in;
            den_ff[i] <= den_prev;
            quo_ff[i] <= quo_in;
            cls_ff[i] <= cls_prev;
         end
      end
   end

   assign quo     = quo_ff[mts_pkg::DIV_STG-1];
   assign cls_out = cls_ff[mts_pkg::DIV_STG-1];

endmodule

FILE: hw/rtl/mts_lane.sv
// ----------------------------------------------------------------------------
// Midtones transfer stretch lane
// One channel: threshold compare, the two balance products, numerator and
// denominator, then the quotient pipeline.
// ----------------------------------------------------------------------------
module mts_lane (
   input  logic                          clock,
   input  mts_pkg::mts_ctrl_type         ctrl,
   input  logic [mts_pkg::IN_W-1:0]      sample,
   input  logic [mts_pkg::THR_W-1:0]     thresholds,
   input  logic [mts_pkg::MID_W-1:0]     midtones,
   input  logic                          force_zero,
   output logic [mts_pkg::OUT_W-1:0]     quo,
   output mts_pkg::mts_class_type        cls
);

   logic [mts_pkg::IN_W-1:0]   smp, shadow, highlight;
   logic [mts_pkg::MID_W-1:0]  mid_sat;
   mts_pkg::mts_class_type     cls1_in;

   logic [mts_pkg::IN_W-1:0]   x_ff, sx_ff;
   logic [mts_pkg::MID_W-1:0]  mc_ff, mi_ff;
   mts_pkg::mts_class_type     cls1_ff;

   logic [mts_pkg::PROD_W-1:0] p1_ff, p2_ff;
   mts_pkg::mts_class_type     cls2_ff;

   logic [mts_pkg::NUM_W-1:0]  num_in, num_ff;
   logic [mts_pkg::DEN_W-1:0]  den_in, den_ff;
   mts_pkg::mts_class_type     cls3_in, cls3_ff;

   // Only the low sample bits of the sample and both thresholds count.
   assign smp       = mts_pkg::IN_W'(sample[mts_pkg::SAMPLE_BITS-1:0]);
   assign shadow    = mts_pkg::IN_W'(thresholds[mts_pkg::SAMPLE_BITS-1:0]);
   assign highlight = mts_pkg::IN_W'(thresholds[16 +: mts_pkg::SAMPLE_BITS]);
   assign mid_sat   = (midtones > mts_pkg::MID_ONE) ? mts_pkg::MID_ONE : midtones;

   always_comb begin
      if (force_zero) begin
         cls1_in = mts_pkg::CLS_ZERO;
      end else if (smp < shadow) begin
         cls1_in = mts_pkg::CLS_LOW;
      end else if (smp >= highlight) begin
         cls1_in = mts_pkg::CLS_HIGH;
      end else begin
         cls1_in = mts_pkg::CLS_MID;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         x_ff    <= smp - shadow;
         sx_ff   <= highlight - smp;
         mc_ff   <= mid_sat;
         mi_ff   <= mts_pkg::MID_ONE - mid_sat;
         cls1_ff <= cls1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[1]) begin
         p1_ff   <= mts_pkg::PROD_W'(mi_ff) * mts_pkg::PROD_W'(x_ff);
         p2_ff   <= mts_pkg::PROD_W'(mc_ff) * mts_pkg::PROD_W'(sx_ff);
         cls2_ff <= cls1_ff;
      end
   end

   // 255 * p1 is formed as p1 * 256 - p1.
   always_comb begin
      num_in  = (mts_pkg::NUM_W'(p1_ff) << 8) - mts_pkg::NUM_W'(p1_ff);
      den_in  = mts_pkg::DEN_W'(p1_ff) + mts_pkg::DEN_W'(p2_ff);
      cls3_in = cls2_ff;
      if (cls2_ff == mts_pkg::CLS_MID && den_in == '0) begin
         cls3_in = mts_pkg::CLS_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[2]) begin
         num_ff  <= num_in;
         den_ff  <= den_in;
         cls3_ff <= cls3_in;
      end
   end

   mts_div u_div (
      .clock   (clock),
      .ctrl    (ctrl),
      .num     (num_ff),
      .den     (den_ff),
      .cls     (cls3_ff),
      .quo     (quo),
      .cls_out (cls)
   );

endmodule

FILE: hw/rtl/mts_ctrl.sv
// ----------------------------------------------------------------------------
// Midtones transfer stretch pipeline control
// Valid bit per stage and bubble-collapsing load enables.
// ----------------------------------------------------------------------------
module mts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  rsp_ready,
   output logic                  req_ready,
   output logic                  rsp_valid,
   output mts_pkg::mts_ctrl_type ctrl
);

   logic [mts_pkg::NSTG-1:0] vld_ff, vld_in, en;

   // A stage may load when the result is being taken or when any stage from
   // here to the output holds a bubble.
   for (genvar k = 0; k < mts_pkg::NSTG; k++) begin : g_en
      assign en[k] = rsp_ready | ~(&vld_ff[mts_pkg::NSTG-1:k]);
   end

   always_comb begin
      vld_in[0] = en[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < mts_pkg::NSTG; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign ctrl.en   = en;
   assign req_ready = en[0];
   assign rsp_valid = vld_ff[mts_pkg::NSTG-1];

endmodule

FILE: hw/rtl/midtones_transfer_stretch.sv
// ----------------------------------------------------------------------------
// Midtones transfer stretch
// Maps one pixel of up to three 16-bit samples to 8-bit display values,
// three lanes side by side with a merge register at the output.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Word
//   req_      in         req_valid / req_ready  three 16-bit samples
//   rsp_      out        rsp_valid / rsp_ready  three 8-bit display values
//   csr_      in         csr_valid / csr_ready  3-bit index, 32-bit data
//
// One pixel is accepted per clock while the pipeline has room. Its word passes through
// twelve register stages in all, three for compare, multiply and combine, eight in
// the quotient pipeline (one quotient bit per stage), and the merge register.
// Reset clears the stage valid bits and loads the configuration defaults;
// there is no clearing pass and csr_ready is always high.
// A stalled output only holds the stages behind it that are full, so words
// keep entering until every stage is occupied.
//
module midtones_transfer_stretch (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mts_pkg::IN_W-1:0]          req_sample_red,
   input  logic [mts_pkg::IN_W-1:0]          req_sample_green,
   input  logic [mts_pkg::IN_W-1:0]          req_sample_blue,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mts_pkg::OUT_W-1:0]         rsp_out_red,
   output logic [mts_pkg::OUT_W-1:0]         rsp_out_green,
   output logic [mts_pkg::OUT_W-1:0]         rsp_out_blue,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mts_pkg::THR_W-1:0]         csr_data
);

   // Configuration registers. The user must change them only while the pipeline is empty;
   // the block does not enforce this. The lanes read them directly as a word enters.
   logic [mts_pkg::THR_W-1:0] red_thr_ff, green_thr_ff, blue_thr_ff;
   logic [mts_pkg::MID_W-1:0] red_mid_ff, green_mid_ff, blue_mid_ff;
   logic                      color_mode_ff;

   mts_pkg::mts_ctrl_type     ctrl;

   logic [mts_pkg::OUT_W-1:0] quo_red, quo_green, quo_blue;
   mts_pkg::mts_class_type    cls_red, cls_green, cls_blue;

   logic [mts_pkg::OUT_W-1:0] out_red_ff, out_green_ff, out_blue_ff;

   assign csr_ready = 1'b1;

   // Writes to an index past the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         red_thr_ff    <= mts_pkg::THR_RESET;
         green_thr_ff  <= mts_pkg::THR_RESET;
         blue_thr_ff   <= mts_pkg::THR_RESET;
         red_mid_ff    <= mts_pkg::MID_RESET;
         green_mid_ff  <= mts_pkg::MID_RESET;
         blue_mid_ff   <= mts_pkg::MID_RESET;
         color_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            mts_pkg::REG_RED_THR:   red_thr_ff    <= csr_data;
            mts_pkg::REG_GREEN_THR: green_thr_ff  <= csr_data;
            mts_pkg::REG_BLUE_THR:  blue_thr_ff   <= csr_data;
            mts_pkg::REG_RED_MID:   red_mid_ff    <= csr_data[mts_pkg::MID_W-1:0];
            mts_pkg::REG_GREEN_MID: green_mid_ff  <= csr_data[mts_pkg::MID_W-1:0];
            mts_pkg::REG_BLUE_MID:  blue_mid_ff   <= csr_data[mts_pkg::MID_W-1:0];
            mts_pkg::REG_MODE:      color_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .ctrl      (ctrl)
   );

   // The red lane always runs; in mono mode the green and blue lanes are
   // forced to a zero result as the word enters them.
   mts_lane u_lane_red (
      .clock      (clock),
      .ctrl       (ctrl),
      .sample     (req_sample_red),
      .thresholds (red_thr_ff),
      .midtones   (red_mid_ff),
      .force_zero (1'b0),
      .quo        (quo_red),
      .cls        (cls_red)
   );

   mts_lane u_lane_green (
      .clock      (clock),
      .ctrl       (ctrl),
      .sample     (req_sample_green),
      .thresholds (green_thr_ff),
      .midtones   (green_mid_ff),
      .force_zero (~color_mode_ff),
      .quo        (quo_green),
      .cls        (cls_green)
   );

   mts_lane u_lane_blue (
      .clock      (clock),
      .ctrl       (ctrl),
      .sample     (req_sample_blue),
      .thresholds (blue_thr_ff),
      .midtones   (blue_mid_ff),
      .force_zero (~color_mode_ff),
      .quo        (quo_blue),
      .cls        (cls_blue)
   );

   // Merge stage: each lane's class picks clipped, zero or quotient, and the
   // three values are registered together as one output word.
   always_ff @(posedge clock) begin
      if (ctrl.en[mts_pkg::NSTG-1]) begin
         out_red_ff   <= mts_pkg::resolve(cls_red, quo_red);
         out_green_ff <= mts_pkg::resolve(cls_green, quo_green);
         out_blue_ff  <= mts_pkg::resolve(cls_blue, quo_blue);
      end
   end

   assign rsp_out_red   = out_red_ff;
   assign rsp_out_green = out_green_ff;
   assign rsp_out_blue  = out_blue_ff;

`ifndef SYNTHESIS
   // In mono mode the green and blue values of every word are zero.
   a_mono_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !color_mode_ff) |-> (rsp_out_green == '0 && rsp_out_blue == '0))
      else $error("mono mode word carries nonzero green or blue");

   // An empty output stage always leaves room for a new word.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty output stage");

   // When the consumer takes words the pipeline never stalls the producer.
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output is being drained");
`endif

endmodule

FILE: verif/tb_midtones_transfer_stretch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midtones transfer stretch testbench
// Streams pixels through the stretch block under several threshold, midtones
// and mode settings, with random stalls on both channels, and checks every
// display word against a cycle-free integer model of the transfer curve.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [mts_pkg::OUT_W-1:0] red;
   logic [mts_pkg::OUT_W-1:0] green;
   logic [mts_pkg::OUT_W-1:0] blue;
} display_word_type;

// Scoreboard: keeps its own copy of the configuration, predicts the display
// word of each accepted pixel and checks the words in order.
class stretch_scoreboard;
   logic [mts_pkg::THR_W-1:0] red_thr, green_thr, blue_thr;
   logic [mts_pkg::MID_W-1:0] red_mid, green_mid, blue_mid;
   logic                      color_mode;
   display_word_type          pending_words [$];
   int                        errors;

   function new();
      red_thr    = mts_pkg::THR_RESET;
      green_thr  = mts_pkg::THR_RESET;
      blue_thr   = mts_pkg::THR_RESET;
      red_mid    = mts_pkg::MID_RESET;
      green_mid  = mts_pkg::MID_RESET;
      blue_mid   = mts_pkg::MID_RESET;
      color_mode = 1'b0;
      errors     = 0;
   endfunction

   function void apply_register(logic [mts_pkg::CSR_IDX_W-1:0] index,
                                logic [mts_pkg::THR_W-1:0] data);
      case (index)
         mts_pkg::REG_RED_THR:   red_thr    = data;
         mts_pkg::REG_GREEN_THR: green_thr  = data;
         mts_pkg::REG_BLUE_THR:  blue_thr   = data;
         mts_pkg::REG_RED_MID:   red_mid    = data[mts_pkg::MID_W-1:0];
         mts_pkg::REG_GREEN_MID: green_mid  = data[mts_pkg::MID_W-1:0];
         mts_pkg::REG_BLUE_MID:  blue_mid   = data[mts_pkg::MID_W-1:0];
         mts_pkg::REG_MODE:      color_mode = data[0];
         default: ;
      endcase
   endfunction

   // One channel of the transfer curve, in exact integer arithmetic.
   function logic [mts_pkg::OUT_W-1:0] mtf_display_value(
      logic [mts_pkg::IN_W-1:0] sample, logic [mts_pkg::THR_W-1:0] thr,
      logic [mts_pkg::MID_W-1:0] mid);
      longint unsigned mask, s, shadow, highlight, m, x, span, num, den;
      mask      = (64'd1 << mts_pkg::SAMPLE_BITS) - 1;
      s         = sample & mask;
      shadow    = thr[15:0] & mask;
      highlight = thr[31:16] & mask;
      if (s < shadow)
         return '0;
      if (s >= highlight)
         return mts_pkg::OUT_MAX;
      m    = (mid > mts_pkg::MID_ONE) ? 64'(mts_pkg::MID_ONE) : 64'(mid);
      x    = s - shadow;
      span = highlight - shadow;
      num  = mts_pkg::OUT_MAX * (mts_pkg::MID_ONE - m) * x;
      den  = m * (span - x) + (mts_pkg::MID_ONE - m) * x;
      if (den == 0)
         return '0;
      return mts_pkg::OUT_W'(num / den);
   endfunction

   function void note_pixel(logic [mts_pkg::IN_W-1:0] r, logic [mts_pkg::IN_W-1:0] g,
                            logic [mts_pkg::IN_W-1:0] b);
      display_word_type w;
      w.red = mtf_display_value(r, red_thr, red_mid);
      if (color_mode) begin
         w.green = mtf_display_value(g, green_thr, green_mid);
         w.blue  = mtf_display_value(b, blue_thr, blue_mid);
      end else begin
         w.green = '0;
         w.blue  = '0;
      end
      pending_words.push_back(w);
   endfunction

   function void check_word(logic [mts_pkg::OUT_W-1:0] r, logic [mts_pkg::OUT_W-1:0] g,
                            logic [mts_pkg::OUT_W-1:0] b);
      display_word_type w;
      if (pending_words.size() == 0) begin
         $display("%0t: unexpected word red=%0d green=%0d blue=%0d", $time, r, g, b);
         errors++;
         return;
      end
      w = pending_words.pop_front();
      if (r !== w.red) begin
         $display("%0t: red mismatch expected %0d actual %0d", $time, w.red, r);
         errors++;
      end
      if (g !== w.green) begin
         $display("%0t: green mismatch expected %0d actual %0d", $time, w.green, g);
         errors++;
      end
      if (b !== w.blue) begin
         $display("%0t: blue mismatch expected %0d actual %0d", $time, w.blue, b);
         errors++;
      end
   endfunction

   function int outstanding();
      return pending_words.size();
   endfunction
endclass

module tb_midtones_transfer_stretch;

   // Index that decodes to no register; a write to it must change nothing.
   localparam logic [mts_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   localparam int RANDOM_PHASES  = 10;
   // Cycles without any handshake before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   // Extra cycles after the last word, to catch stray words from the pipeline.
   localparam int END_HOLD       = 2 * mts_pkg::NSTG;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [mts_pkg::IN_W-1:0]      req_sample_red;
   logic [mts_pkg::IN_W-1:0]      req_sample_green;
   logic [mts_pkg::IN_W-1:0]      req_sample_blue;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [mts_pkg::OUT_W-1:0]     rsp_out_red;
   logic [mts_pkg::OUT_W-1:0]     rsp_out_green;
   logic [mts_pkg::OUT_W-1:0]     rsp_out_blue;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [mts_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mts_pkg::THR_W-1:0]     csr_data;

   // Set for the final phase: from then on neither side inserts idle cycles.
   logic                          calm;

   stretch_scoreboard             sb;

   midtones_transfer_stretch uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_red   (req_sample_red),
      .req_sample_green (req_sample_green),
      .req_sample_blue  (req_sample_blue),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // All handshakes are observed here, at the rising edge, in one place. The
   // scoreboard sees register writes, accepted pixels and returned words in
   // the order the block sees them.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.apply_register(csr_index, csr_data);
         if (req_valid && req_ready)
            sb.note_pixel(req_sample_red, req_sample_green, req_sample_blue);
         if (rsp_valid && rsp_ready)
            sb.check_word(rsp_out_red, rsp_out_green, rsp_out_blue);
      end
   end

   // Watchdog: ends the run if no handshake happens for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("status: fail");
      $finish;
   end

   // Result side: runs of ready of random length, broken now and then by stall
   // bursts until the final phase begins.
   initial begin
      int run_left;
      int stall_left;
      run_left   = 0;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if (run_left > 0) begin
               run_left--;
            end else begin
               run_left = $urandom_range(0, 40);
               if (!calm && $urandom_range(0, 1) == 1)
                  stall_left = $urandom_range(1, 17);
            end
         end
      end
   end

   // Presents one pixel and holds it until the block takes it. Now and then the
   // sender goes quiet for a burst of cycles afterwards.
   task automatic send_pixel(input logic [mts_pkg::IN_W-1:0] r,
                             input logic [mts_pkg::IN_W-1:0] g,
                             input logic [mts_pkg::IN_W-1:0] b);
      int gap;
      @(negedge clock);
      req_valid        = 1'b1;
      req_sample_red   = r;
      req_sample_green = g;
      req_sample_blue  = b;
      do @(posedge clock); while (!req_ready);
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 17);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every predicted word has come back, so the
   // configuration can be changed safely.
   task automatic wait_for_quiet();
      @(negedge clock);
      req_valid = 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic program_register(input logic [mts_pkg::CSR_IDX_W-1:0] index,
                                   input logic [mts_pkg::THR_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Threshold pairs: full random words, the reset pair, all ones, all zeros,
   // very narrow windows and ordinary ordered windows.
   function automatic logic [mts_pkg::THR_W-1:0] pick_thresholds();
      logic [15:0] a, b, t;
      logic [mts_pkg::THR_W-1:0] v;
      a = 16'($urandom);
      b = 16'($urandom);
      case ($urandom_range(0, 7))
         0: v = $urandom;
         1: v = mts_pkg::THR_RESET;
         2: v = '1;
         3: v = '0;
         4: begin
            b = a + 16'($urandom_range(1, 4));
            if (b < a)
               b = 16'hFFFF;
            v = {b, a};
         end
         default: begin
            if (a > b) begin
               t = a;
               a = b;
               b = t;
            end
            v = {b, a};
         end
      endcase
      return v;
   endfunction

   // Midtones balance, with the ends of the range and values above one.
   function automatic logic [mts_pkg::MID_W-1:0] pick_midtones();
      logic [mts_pkg::MID_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = 17'd1;
         2: v = 17'd65535;
         3: v = mts_pkg::MID_ONE;
         4: v = 17'($urandom_range(65537, 131071));
         default: v = 17'($urandom_range(0, 65536));
      endcase
      return v;
   endfunction

   // Samples are mostly inside the channel's window, where the curve is bent,
   // with the window edges and full-range values mixed in.
   function automatic logic [mts_pkg::IN_W-1:0] pick_sample(
      input logic [mts_pkg::THR_W-1:0] thr);
      logic [15:0] lo, hi, v;
      lo = thr[15:0];
      hi = thr[31:16];
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            if (hi > lo)
               v = lo + 16'($urandom_range(0, hi - lo - 1));
            else
               v = 16'($urandom);
         end
         6: v = lo;
         7: v = hi;
         8: v = ($urandom_range(0, 1) == 1) ? hi - 16'd1 : lo - 16'd1;
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   // Rewrites a random subset of the registers, sometimes also poking the
   // unused index. Upper data bits beyond a register's width are random.
   task automatic randomize_settings();
      logic [mts_pkg::THR_W-1:0] hi_bits;
      if ($urandom_range(0, 3) != 0)
         program_register(mts_pkg::REG_RED_THR, pick_thresholds());
      if ($urandom_range(0, 3) != 0)
         program_register(mts_pkg::REG_GREEN_THR, pick_thresholds());
      if ($urandom_range(0, 3) != 0)
         program_register(mts_pkg::REG_BLUE_THR, pick_thresholds());
      hi_bits = $urandom & 32'hFFFE_0000;
      if ($urandom_range(0, 3) != 0)
         program_register(mts_pkg::REG_RED_MID, hi_bits | 32'(pick_midtones()));
      hi_bits = $urandom & 32'hFFFE_0000;
      if ($urandom_range(0, 3) != 0)
         program_register(mts_pkg::REG_GREEN_MID, hi_bits | 32'(pick_midtones()));
      hi_bits = $urandom & 32'hFFFE_0000;
      if ($urandom_range(0, 3) != 0)
         program_register(mts_pkg::REG_BLUE_MID, hi_bits | 32'(pick_midtones()));
      if ($urandom_range(0, 3) != 0) program_register(mts_pkg::REG_MODE, $urandom);
      if ($urandom_range(0, 3) == 0) program_register(REG_UNUSED, $urandom);
   endtask

   initial begin
      int n_items;
      sb               = new();
      calm             = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_red   = '0;
      req_sample_green = '0;
      req_sample_blue  = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: mono, full window, balance one half. The green and
      // blue samples carry noise that must not reach the outputs.
      send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
      send_pixel(16'hFFFF, 16'h1234, 16'h0000);
      send_pixel(16'h8000, 16'h0000, 16'h0000);
      send_pixel(16'h0001, 16'hAAAA, 16'h5555);
      send_pixel(16'hFFFE, 16'h5555, 16'hAAAA);

      // Color mode. Red has a window of 1000 to 60000 with balance zero, so
      // a sample on the shadow gives a zero denominator. Green has an empty
      // window at zero, so every sample is a highlight. Blue has a balance
      // above one, which saturates to one and flattens the window to zero.
      wait_for_quiet();
      program_register(mts_pkg::REG_MODE, 32'd1);
      program_register(mts_pkg::REG_RED_THR, {16'd60000, 16'd1000});
      program_register(mts_pkg::REG_GREEN_THR, 32'd0);
      program_register(mts_pkg::REG_BLUE_THR, {16'd50000, 16'd10000});
      program_register(mts_pkg::REG_RED_MID, 32'd0);
      program_register(mts_pkg::REG_GREEN_MID, 32'(mts_pkg::MID_ONE));
      program_register(mts_pkg::REG_BLUE_MID, 32'h0001_FFFF);
      program_register(REG_UNUSED, 32'hDEAD_BEEF);
      send_pixel(16'd999, 16'd0, 16'd9999);
      send_pixel(16'd1000, 16'd1, 16'd10000);
      send_pixel(16'd1001, 16'd65535, 16'd10001);
      send_pixel(16'd59999, 16'd30000, 16'd49999);
      send_pixel(16'd60000, 16'd12345, 16'd50000);
      send_pixel(16'd65535, 16'd0, 16'd0);
      send_pixel(16'd0, 16'hFFFF, 16'hFFFF);
      send_pixel(16'd30000, 16'd0, 16'd30000);

      // Green's highlight below its shadow: samples split at the shadow into
      // zero and full scale. Balances next to both ends on the other lanes.
      wait_for_quiet();
      program_register(mts_pkg::REG_GREEN_THR, {16'd20000, 16'd40000});
      program_register(mts_pkg::REG_RED_MID, 32'd65535);
      program_register(mts_pkg::REG_GREEN_MID, 32'd1);
      program_register(mts_pkg::REG_BLUE_MID, 32'd1);
      program_register(mts_pkg::REG_BLUE_THR, mts_pkg::THR_RESET);
      send_pixel(16'd1000, 16'd39999, 16'd0);
      send_pixel(16'd59999, 16'd40000, 16'd1);
      send_pixel(16'd1001, 16'd20000, 16'd65534);
      send_pixel(16'd30000, 16'd65535, 16'd32768);
      send_pixel(16'd2000, 16'd19999, 16'd65535);

      // Random phases. Every change of settings happens with the pipeline
      // drained, which also makes the sender wait for all words each time.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_quiet();
         if (phase == RANDOM_PHASES - 1)
            calm = 1'b1;
         randomize_settings();
         n_items = $urandom_range(60, 85);
         repeat (n_items)
            send_pixel(pick_sample(sb.red_thr), pick_sample(sb.green_thr),
                       pick_sample(sb.blue_thr));
      end

      wait_for_quiet();
      repeat (END_HOLD) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: midtones_transfer_stretch.f
hw/rtl/mts_pkg.sv
hw/rtl/mts_div.sv
hw/rtl/mts_lane.sv
hw/rtl/mts_ctrl.sv
hw/rtl/midtones_transfer_stretch.sv
verif/tb_midtones_transfer_stretch.sv
